>>> rtl/assert_macros.svh
// Assertion macros shared by the text console RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// ante at an edge implies cons at the same edge
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante at an edge implies cons at the next edge
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// Package for the text console writer: geometry, codes, payload and link types.
// No dependencies.
`default_nettype none

package tcw_pkg;

   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = ROWS * COLS;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = $clog2(COLS + 1);

   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;

   localparam logic [CNT_W-1:0]  CNT_LAST    = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]  CNT_END     = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0]  CNT_SHIFT   = CNT_W'(CELLS - COLS);
   localparam logic [CNT_W-1:0]  CNT_COLS    = CNT_W'(COLS);
   localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'((ROWS - 1) * COLS);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_FULL    = COL_W'(COLS);

   // actions
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // characters
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] SPACE_CODE   = 8'h20;

   // configuration register indexes
   localparam logic [1:0] CSR_FG_COLOR = 2'd0;
   localparam logic [1:0] CSR_BG_COLOR = 2'd1;

   typedef logic [15:0] cell_type;   // {attr, char}

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0]             cell_char;
      logic [7:0]             cell_attr;
      logic [ROW_FIELD_W-1:0] cursor_row_out;
      logic [COL_FIELD_W-1:0] cursor_col_out;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      cell_type          wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic                   done_read;
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
   } seq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCROLL,
      ST_TAIL
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * COLS + int'(col));
   endfunction

endpackage

`default_nettype wire

>>> rtl/tcw_screen.sv
// Screen cell store: one write port and one registered read port.
// Depends on tcw_pkg.
`default_nettype none

module tcw_screen (
   input  logic                 clock,
   input  tcw_pkg::mem_req_type mem_req,
   output tcw_pkg::cell_type    rd_data
);
   import tcw_pkg::*;

   cell_type mem [CELLS];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tcw_seq.sv
// Sequencer: cursor, one address counter swept for clear and scroll, store requests.
// Depends on tcw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcw_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  tcw_pkg::req_type        req,
   input  logic [3:0]              fg_color,
   input  logic [3:0]              bg_color,
   input  tcw_pkg::cell_type       rd_data,
   output tcw_pkg::mem_req_type    mem_req,
   output tcw_pkg::seq_status_type status
);
   import tcw_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             put_char_ff, put_char_in;
   logic [7:0]       char_ff, char_in;

   logic             is_put, is_nl, need_nl, scroll, in_range;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] wr_col;
   logic [7:0]       attr;
   logic             done, done_read;

   // decode of the offered item against the cursor
   always_comb begin
      is_put   = req.action == ACT_PUT;
      is_nl    = req.char_code == NEWLINE_CODE;
      need_nl  = is_put && (is_nl || col_ff >= COL_FULL);
      scroll   = need_nl && (row_ff == ROW_LAST);
      wr_row   = need_nl ? row_ff + ROW_W'(1) : row_ff;
      wr_col   = need_nl ? '0 : col_ff;
      in_range = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLS);
      attr     = {bg_color, fg_color};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_put && scroll) begin
                  state_in = ST_SCROLL;
               end else if (req.action == ACT_CLEAR) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_TAIL;
            end
         end
         ST_SCROLL: begin
            if (cnt_ff == CNT_END) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cursor, counter and held character
   always_comb begin
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      put_char_in = put_char_ff;
      char_in     = char_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in      = '0;
               put_char_in = is_put && !is_nl;
               char_in     = req.char_code;
               if (is_put) begin
                  if (scroll) begin
                     col_in = is_nl ? '0 : COL_W'(1);
                  end else if (is_nl) begin
                     row_in = wr_row;
                     col_in = '0;
                  end else begin
                     row_in = wr_row;
                     col_in = wr_col + COL_W'(1);
                  end
               end
            end
         end
         ST_CLEAR, ST_SCROLL: begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_TAIL: begin
            put_char_in = 1'b0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // store requests and completion
   always_comb begin
      mem_req   = '0;
      done      = 1'b0;
      done_read = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_put && !is_nl && !scroll) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cell_addr(wr_row, wr_col);
               mem_req.wr_data = {attr, req.char_code};
            end
            if (accept && req.action == ACT_READ && in_range) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cell_addr(ROW_W'(req.read_row), COL_W'(req.read_col));
            end
            done      = accept && !(is_put && scroll) && req.action != ACT_CLEAR;
            done_read = accept && req.action == ACT_READ && in_range;
         end
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_W'(cnt_ff);
            mem_req.wr_data = {attr, SPACE_CODE};
         end
         ST_SCROLL: begin
            // read one row ahead, write back in the next cycle
            mem_req.rd_en   = cnt_ff < CNT_SHIFT;
            mem_req.rd_addr = ADDR_W'(cnt_ff + CNT_COLS);
            mem_req.wr_en   = cnt_ff != '0;
            mem_req.wr_addr = ADDR_W'(cnt_ff - CNT_W'(1));
            mem_req.wr_data = (cnt_ff <= CNT_SHIFT) ? rd_data : {attr, SPACE_CODE};
         end
         ST_TAIL: begin
            mem_req.wr_en   = put_char_ff;
            mem_req.wr_addr = BOTTOM_ADDR;
            mem_req.wr_data = {attr, char_ff};
            done            = 1'b1;
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_comb begin
      status.busy       = state_ff != ST_IDLE;
      status.done       = done;
      status.done_read  = done_read;
      status.cursor_row = ROW_FIELD_W'(row_ff);
      status.cursor_col = COL_FIELD_W'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         put_char_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         put_char_ff <= put_char_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
   end

   `TCW_ASSERT_ALWAYS(a_cursor_bound, clock, reset, (row_ff <= ROW_LAST) && (col_ff <= COL_FULL), "cursor out of screen")
   `TCW_ASSERT_NEXT(a_scroll_end, clock, reset, (state_ff == ST_SCROLL) && (cnt_ff == CNT_END), state_ff == ST_TAIL, "scroll sweep did not finish")
   `TCW_ASSERT_IMP(a_idle_write, clock, reset, mem_req.wr_en && (state_ff == ST_IDLE), accept && (req.action == ACT_PUT), "idle write without put transfer")

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
// Text console writer: a ROWS x COLS character/attribute store with a cursor.
// An ordinary put, a newline without scroll, a read or an unused action
// needs no sweep, and such requests are taken back to back, also while a
// finished response still waits behind rsp_stall (one response is held in a
// pending slot, one in the output register). A newline or wrap on the bottom
// row scrolls: the store is swept once through its single read and write
// port before the response. A clear sweeps every cell once. The store is not
// cleared after reset: a cell reads as garbage until written by a put, clear
// or scroll.
// Depends on tcw_pkg, tcw_seq, tcw_screen and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module text_console_writer (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_data,
   // register writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [3:0]       csr_data
);
   import tcw_pkg::*;

   // color registers
   logic [3:0] fg_color_ff, fg_color_in;
   logic [3:0] bg_color_ff, bg_color_in;

   // pending slot: result of a finished item, not yet in the output register
   logic pend_valid_ff, pend_valid_in;
   logic pend_read_ff, pend_read_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           rsp_free;
   logic           pend_move;
   mem_req_type    mem_req;
   cell_type       rd_data;
   seq_status_type status;

   // register writes are taken at once; software must make writes only when idle, which the block leaves unchecked
   assign csr_ready = 1'b1;

   always_comb begin
      fg_color_in = fg_color_ff;
      bg_color_in = bg_color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FG_COLOR: fg_color_in = csr_data;
            CSR_BG_COLOR: bg_color_in = csr_data;
            default:      fg_color_in = fg_color_ff;
         endcase
      end
   end

   // output register frees this cycle if empty or being taken
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_move = pend_valid_ff && rsp_free;

   // stall while sweeping, or while the pending slot cannot drain
   assign req_stall = status.busy || (pend_valid_ff && !rsp_free);
   assign accept    = req_valid && !req_stall;

   // pending slot: at a transfer it is empty or draining, so a new done
   // never overwrites a live result
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_read_in  = pend_read_ff;
      if (status.done) begin
         pend_valid_in = 1'b1;
         pend_read_in  = status.done_read;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
   end

   // response build: cursor and read data are still those left by the
   // pending item when it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pend_move) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.cell_char      = pend_read_ff ? rd_data[7:0] : 8'h00;
         rsp_data_in.cell_attr      = pend_read_ff ? rd_data[15:8] : 8'h00;
         rsp_data_in.cursor_row_out = status.cursor_row;
         rsp_data_in.cursor_col_out = status.cursor_col;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff   <= 4'hF;
         bg_color_ff   <= 4'h0;
         pend_valid_ff <= 1'b0;
         pend_read_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fg_color_ff   <= fg_color_in;
         bg_color_ff   <= bg_color_in;
         pend_valid_ff <= pend_valid_in;
         pend_read_ff  <= pend_read_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer: cursor, sweep counter, store requests
   tcw_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .fg_color (fg_color_ff),
      .bg_color (bg_color_ff),
      .rd_data  (rd_data),
      .mem_req  (mem_req),
      .status   (status)
   );

   // character store
   tcw_screen u_screen (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   `TCW_ASSERT_NEXT(a_pend_hold, clock, reset, pend_valid_ff && !rsp_free, pend_valid_ff, "pending result lost while output blocked")

endmodule

`default_nettype wire
